/* hw/rtl/sha256bs_pkg.sv */
package sha256bs_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] r;
		case (t)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/sha256bs_if.sv */
interface sha256bs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last_byte;

	modport source (output valid, data_byte, has_byte, last_byte, input ready);
	modport sink (input valid, data_byte, has_byte, last_byte, output ready);
endinterface

interface sha256bs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic        last_word;

	modport source (output valid, digest_word, last_word, input ready);
	modport sink (input valid, digest_word, last_word, output ready);
endinterface

/* hw/rtl/sha256_byte_stream_hasher.sv */
// channel | dir | payload                         | beat
// msg     | in  | data_byte, has_byte, last_byte  | one byte or end marker
// digest  | out | digest_word, last_word          | one digest word, H0 first
//
// every 64th byte starts a compression: 64 rounds, then the state add
// a last beat adds the pad bytes, one at a time, plus one or two compressions
// and then 8 digest beats; one round unit does all compression work
// msg.ready is high only while idle; digest beats stall freely on digest.ready
// arst_n clears control and loads the initial hash values
module sha256_byte_stream_hasher (
	input  logic clk,
	input  logic arst_n,
	sha256bs_in_if.sink    msg,
	sha256bs_out_if.source digest
);

	sha256bs_pkg::state_t state_q, state_d;

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  fill_q;
	logic [60:0] len_q;
	logic [5:0]  round_q;
	logic [2:0]  idx_q;
	logic        pad_q;     // message ended, padding in progress
	logic        mark_q;    // 0x80 already placed
	logic        fin_blk_q; // current block carries the length
	logic        fin_q;     // last block filled

	logic        acc;
	logic        shift_en;
	logic [7:0]  byte_in;
	logic [7:0]  pad_byte;
	logic [63:0] bits;
	logic [31:0] s0, s1, ch, maj, t1, t2, g0, g1, w_new;

	assign acc = msg.valid && msg.ready;
	assign msg.ready = (state_q == sha256bs_pkg::ST_IDLE);
	assign digest.valid = (state_q == sha256bs_pkg::ST_OUT);
	assign digest.digest_word = h_q[idx_q];
	assign digest.last_word = (idx_q == 3'd7);

	// pad byte selection: marker, zeros, then big-endian bit length
	assign bits = {len_q, 3'b000};
	always_comb begin
		if (!mark_q) begin
			pad_byte = sha256bs_pkg::PAD_MARK;
		end else if (fin_blk_q && fill_q >= sha256bs_pkg::LEN_START) begin
			pad_byte = bits[{3'd7 - fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign byte_in = (state_q == sha256bs_pkg::ST_PAD) ? pad_byte : msg.data_byte;
	assign shift_en = (acc && msg.has_byte) || (state_q == sha256bs_pkg::ST_PAD);

	// shared round unit
	assign s1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		^ {v_q[4][24:0], v_q[4][31:25]};
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + s1 + ch + sha256bs_pkg::round_k(round_q) + w_q[0];
	assign s0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		^ {v_q[0][21:0], v_q[0][31:22]};
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2 = s0 + maj;

	// rolling schedule window, w_q[0] is the word of the current round
	assign g0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
		^ (w_q[1] >> 3);
	assign g1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ (w_q[14] >> 10);
	assign w_new = g1 + w_q[9] + g0 + w_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256bs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256bs_pkg::ST_IDLE: begin
				if (acc && msg.has_byte && fill_q == 6'd63) begin
					state_d = sha256bs_pkg::ST_ROUND;
				end else if (acc && msg.last_byte) begin
					state_d = sha256bs_pkg::ST_PAD;
				end
			end
			sha256bs_pkg::ST_PAD: begin
				if (fill_q == 6'd63) begin
					state_d = sha256bs_pkg::ST_ROUND;
				end
			end
			sha256bs_pkg::ST_ROUND: begin
				if (round_q == 6'd63) begin
					state_d = sha256bs_pkg::ST_ADD;
				end
			end
			sha256bs_pkg::ST_ADD: begin
				if (fin_q) begin
					state_d = sha256bs_pkg::ST_OUT;
				end else if (pad_q) begin
					state_d = sha256bs_pkg::ST_PAD;
				end else begin
					state_d = sha256bs_pkg::ST_IDLE;
				end
			end
			sha256bs_pkg::ST_OUT: begin
				if (digest.ready && idx_q == 3'd7) begin
					state_d = sha256bs_pkg::ST_IDLE;
				end
			end
			default: state_d = sha256bs_pkg::ST_IDLE;
		endcase
	end

	// control and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha256bs_pkg::init_h(3'(i));
			end
			fill_q    <= '0;
			len_q     <= '0;
			round_q   <= '0;
			idx_q     <= '0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			fin_blk_q <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (acc && msg.has_byte) begin
				len_q <= len_q + 61'd1;
			end
			if (acc && msg.last_byte) begin
				pad_q <= 1'b1;
			end
			if (state_q == sha256bs_pkg::ST_PAD) begin
				mark_q <= 1'b1;
				if (!mark_q && fill_q < sha256bs_pkg::LEN_START) begin
					fin_blk_q <= 1'b1;
				end
				if (fin_blk_q && fill_q == 6'd63) begin
					fin_q <= 1'b1;
				end
			end
			if (state_q == sha256bs_pkg::ST_ROUND) begin
				round_q <= round_q + 6'd1;
			end else begin
				round_q <= '0;
			end
			if (state_q == sha256bs_pkg::ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
				if (pad_q && mark_q) begin
					fin_blk_q <= 1'b1;
				end
			end
			if (digest.valid && digest.ready) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= sha256bs_pkg::init_h(3'(i));
					end
					fill_q    <= '0;
					len_q     <= '0;
					pad_q     <= 1'b0;
					mark_q    <= 1'b0;
					fin_blk_q <= 1'b0;
					fin_q     <= 1'b0;
				end
			end
		end
	end

	// payload: message window and working variables
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], byte_in};
		end else if (state_q == sha256bs_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (state_q == sha256bs_pkg::ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end
	end

	// never accepting input while digest words are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("input accepted during digest output");

	// rounds advance one per cycle
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256bs_pkg::ST_ROUND && round_q != 6'd63)
		|=> (round_q == $past(round_q) + 6'd1))
		else $error("round counter skipped");

	// final digest beat returns the block to idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.last_word) |=> msg.ready)
		else $error("not idle after digest");

	// digest starts only after the length block was filled
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest.valid) |-> fin_q)
		else $error("digest without final block");

endmodule

/* dv/sha256_digest_sb.sv */
class sha256_digest_sb;
	bit [31:0] hash_words [8];
	bit [7:0]  block_bytes [64];
	int unsigned fill_count;
	bit [60:0] byte_count;
	bit [31:0] pending_words [$];
	bit        pending_last [$];
	int unsigned error_count;

	function new();
		restart();
		error_count = 0;
	endfunction

	function void restart();
		hash_words = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		fill_count = 0;
		byte_count = '0;
	endfunction

	function bit [31:0] rotr(bit [31:0] v, int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	// one 64-round compression of block_bytes into hash_words
	function void compress_block();
		bit [31:0] w [64];
		bit [31:0] v [8];
		bit [31:0] t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
				block_bytes[4*t+3]};
		for (int t = 16; t < 64; t++)
			w[t] = w[t-16] + w[t-7]
				+ (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
				+ (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
		v = hash_words;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256bs_pkg::round_k(t[5:0]) + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_words[i] += v[i];
	endfunction

	// note an accepted msg beat
	function void note_msg_beat(bit [7:0] data, bit has_byte, bit last_byte);
		bit [63:0] bit_len;
		if (has_byte) begin
			block_bytes[fill_count] = data;
			fill_count = (fill_count + 1) % 64;
			byte_count = byte_count + 1;
			if (fill_count == 0)
				compress_block();
		end
		if (!last_byte)
			return;
		bit_len = {byte_count, 3'b000};
		block_bytes[fill_count] = sha256bs_pkg::PAD_MARK;
		fill_count++;
		if (fill_count > 56) begin
			while (fill_count < 64)
				block_bytes[fill_count++] = 8'h00;
			compress_block();
			fill_count = 0;
		end
		while (fill_count < 56)
			block_bytes[fill_count++] = 8'h00;
		for (int i = 0; i < 8; i++)
			block_bytes[56 + i] = bit_len[(7 - i) * 8 +: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			pending_words.push_back(hash_words[i]);
			pending_last.push_back(i == 7);
		end
		restart();
	endfunction

	// check an accepted digest beat against the oldest pending word
	function void check_digest_beat(bit [31:0] word, bit last_word);
		bit [31:0] exp_word;
		bit        exp_last;
		if (pending_words.size() == 0) begin
			$display("%0t: unexpected digest beat %h last %b", $time, word, last_word);
			error_count++;
			return;
		end
		exp_word = pending_words.pop_front();
		exp_last = pending_last.pop_front();
		if (word !== exp_word) begin
			$display("%0t: digest_word expected %h actual %h", $time, exp_word, word);
			error_count++;
		end
		if (last_word !== exp_last) begin
			$display("%0t: last_word expected %b actual %b", $time, exp_last, last_word);
			error_count++;
		end
	endfunction
endclass

/* dv/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int unsigned cycle_count = 0;
	bit  calm_run;       // no idling on either side
	bit  hold_digest;    // long receiver hold-off
	int  random_msgs;

	sha256bs_in_if  msg ();
	sha256bs_out_if digest ();
	sha256_digest_sb digest_sb;

	sha256_byte_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg.sink),
		.digest (digest.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous limit: all beats, up to two compressions each, plus stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// digest side: sample at rising edge, change ready at falling edge
	always @(posedge clk)
		if (arst_n && digest.valid && digest.ready)
			digest_sb.check_digest_beat(digest.digest_word, digest.last_word);

	initial begin
		int hold_left;
		bit hold_taken;
		digest.ready = 1'b0;
		hold_left = 0;
		hold_taken = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_digest && !hold_taken) begin
				hold_left = 400;  // long enough that msg stalls behind it
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				digest.ready <= 1'b0;
			end else
				digest.ready <= calm_run ? 1'b1 : ($urandom_range(99) >= 11);
		end
	end

	// drive one msg beat, with a random idle gap first unless calm_run
	task automatic send_beat(bit [7:0] data, bit has_byte, bit last_byte);
		while (!calm_run && $urandom_range(99) < 11) begin
			msg.valid <= 1'b0;
			@(negedge clk);
		end
		msg.valid     <= 1'b1;
		msg.data_byte <= data;
		msg.has_byte  <= has_byte;
		msg.last_byte <= last_byte;
		do
			@(posedge clk);
		while (!msg.ready);
		digest_sb.note_msg_beat(data, has_byte, last_byte);
		@(negedge clk);
	endtask

	// message of random bytes with random no-op beats; last byte optionally split into an end marker
	task automatic send_message(int n_bytes);
		bit split_end;
		split_end = (n_bytes == 0) || $urandom_range(1);
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(9) == 0)
				send_beat(8'($urandom), 1'b0, 1'b0);  // no-op beat
			send_beat(8'($urandom), 1'b1, !split_end && (i == n_bytes - 1));
		end
		if (split_end)
			send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain_digests();
		msg.valid <= 1'b0;
		while (digest_sb.pending_words.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		digest_sb = new();
		calm_run = 1'b0;
		hold_digest = 1'b0;
		msg.valid = 1'b0;
		msg.data_byte = '0;
		msg.has_byte = 1'b0;
		msg.last_byte = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty message, byte with last, extremes, no-op beat, "abc", empty message
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'h5a, 1'b0, 1'b1);
		// sender pauses until every digest word is back
		drain_digests();

		// two-block padding, then a full block of bytes
		send_message(56);
		drain_digests();
		send_message(64);

		// receiver holds off, so the short messages stall at the input
		hold_digest = 1'b1;
		send_message(3);
		send_message(0);
		send_message(5);

		// random short messages, with a calm stretch in the middle
		random_msgs = 0;
		while (random_msgs < 10) begin
			calm_run = (random_msgs >= 2 && random_msgs < 8);
			send_message(int'($urandom_range(10)));
			random_msgs++;
		end
		calm_run = 1'b0;

		drain_digests();
		repeat (200) @(negedge clk);
		if (digest_sb.error_count == 0 && digest_sb.pending_words.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
